### hdl/ip_address_validator_assert.svh
// Assertion macros for the address validator checker.
`ifndef IP_ADDRESS_VALIDATOR_ASSERT_SVH
`define IP_ADDRESS_VALIDATOR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define IPAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define IPAV_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/ipav_pkg.sv
// Package: types and constants of the IPv4/IPv6 address validator.
`timescale 1ns / 1ps

package ipav_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned DotW    = 3;
  localparam int unsigned ColonW  = 4;
  localparam int unsigned LenW    = 3;
  localparam int unsigned ValW    = 10;

  localparam logic [ChW-1:0] ChDot    = 8'h2E;  // '.'
  localparam logic [ChW-1:0] ChColon  = 8'h3A;  // ':'
  localparam logic [ChW-1:0] ChZero   = 8'h30;  // '0'
  localparam logic [ChW-1:0] ChNine   = 8'h39;  // '9'
  localparam logic [ChW-1:0] ChLowA   = 8'h61;  // 'a'
  localparam logic [ChW-1:0] ChLowF   = 8'h66;  // 'f'
  localparam logic [ChW-1:0] ChUpA    = 8'h41;  // 'A'
  localparam logic [ChW-1:0] ChUpF    = 8'h46;  // 'F'

  localparam logic [DotW-1:0]   V4Dots     = 3'd3;
  localparam logic [ColonW-1:0] V6Colons   = 4'd7;
  localparam logic [LenW-1:0]   V4MaxLen   = 3'd3;
  localparam logic [LenW-1:0]   V6MaxLen   = 3'd4;
  localparam logic [ValW-1:0]   V4MaxValue = 10'd255;
  localparam logic [ValW-1:0]   ValSat     = 10'd1023;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_V4   = 2'd1,
    VERDICT_V6   = 2'd2
  } verdict_e;

  // Character class of one input byte.
  typedef struct packed {
    logic       is_dot;
    logic       is_colon;
    logic       is_digit;
    logic       is_hex_letter;
    logic [3:0] digit;
  } char_class_t;

endpackage

### hdl/ipav_if.sv
// Valid/ready channel interfaces: character beats in, verdict beats out.
`timescale 1ns / 1ps

interface ipav_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, ch, has_char, last, input ready);
  modport sink   (input valid, ch, has_char, last, output ready);
endinterface

interface ipav_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

### hdl/ipav_char_class.sv
// Character classifier: sorts one ASCII byte into separator, digit or hex letter.
`timescale 1ns / 1ps

module ipav_char_class
  import ipav_pkg::*;
(
  input  logic [ChW-1:0] ch_i,
  output char_class_t    cls_o
);

  logic [ChW-1:0] digit_off;

  assign digit_off = ch_i - ChZero;

  always_comb begin
    cls_o.is_dot        = (ch_i == ChDot);
    cls_o.is_colon      = (ch_i == ChColon);
    cls_o.is_digit      = (ch_i >= ChZero) && (ch_i <= ChNine);
    cls_o.is_hex_letter = ((ch_i >= ChLowA) && (ch_i <= ChLowF)) ||
                          ((ch_i >= ChUpA) && (ch_i <= ChUpF));
    cls_o.digit         = digit_off[3:0];
  end

endmodule

### hdl/ip_address_validator.sv
// Top level: streaming IPv4 / IPv6 address text validator.
`timescale 1ns / 1ps

// Channel | Dir | Payload                 | Beat
// in_i    | in  | ch[7:0], has_char, last | one character (or end-only mark)
// out_o   | out | verdict[1:0]            | one verdict per text, on last
//
// One character per cycle unless a last beat waits on a stalled verdict.
// A beat lands in the input register, then the next cycle the classifier
// and part/counter update run between that register and the scan state,
// and a last beat loads the verdict register. Its verdict passes the input
// register and then the result register before it shows valid.
// Reset sets the scan start state, clears both valid flags; no clearing pass.
// in_i.ready drops only when a last beat waits on a stalled verdict.

module ip_address_validator
  import ipav_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ipav_in_if.sink    in_i,
  ipav_out_if.source out_o
);

  // Input register
  logic           in_vld_q;
  logic [ChW-1:0] ch_q;
  logic           has_q;
  logic           last_q;

  // Scan state
  logic              v4_ok_q,  v4_ok_d;
  logic              v6_ok_q,  v6_ok_d;
  logic [DotW-1:0]   dot_q,    dot_d;
  logic [ColonW-1:0] colon_q,  colon_d;
  logic [LenW-1:0]   v4_len_q, v4_len_d;
  logic [LenW-1:0]   v6_len_q, v6_len_d;
  logic [ValW-1:0]   pval_q,   pval_d;
  logic              lz_q,     lz_d;

  // Result register
  logic     out_vld_q;
  verdict_e verdict_q, verdict_d;

  char_class_t cls;
  logic        advance;
  logic [13:0] pval_mul;
  logic        is_v4, is_v6;

  ipav_char_class u_cls (
    .ch_i  (ch_q),
    .cls_o (cls)
  );

  // A non-last beat never needs the result register.
  assign advance    = in_vld_q && (!last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  assign out_o.valid   = out_vld_q;
  assign out_o.verdict = verdict_q;

  // part * 10 + digit, as shift-add
  assign pval_mul = {1'b0, pval_q, 3'b000} + {3'b000, pval_q, 1'b0} + {10'd0, cls.digit};

  always_comb begin
    v4_ok_d  = v4_ok_q;
    v6_ok_d  = v6_ok_q;
    dot_d    = dot_q;
    colon_d  = colon_q;
    v4_len_d = v4_len_q;
    v6_len_d = v6_len_q;
    pval_d   = pval_q;
    lz_d     = lz_q;
    if (has_q) begin
      if (cls.is_dot) begin
        dot_d    = (dot_q != '1) ? dot_q + 1'b1 : dot_q;
        if (v4_len_q == '0) v4_ok_d = 1'b0;
        v4_len_d = '0;
        pval_d   = '0;
        lz_d     = 1'b0;
        v6_ok_d  = 1'b0;
      end else if (cls.is_colon) begin
        colon_d  = (colon_q != '1) ? colon_q + 1'b1 : colon_q;
        if (v6_len_q == '0) v6_ok_d = 1'b0;
        v6_len_d = '0;
        v4_ok_d  = 1'b0;
      end else if (cls.is_digit) begin
        if (v4_len_q == '0) begin
          lz_d = (cls.digit == 4'd0);
        end else if (lz_q) begin
          v4_ok_d = 1'b0;
        end
        v4_len_d = (v4_len_q != '1) ? v4_len_q + 1'b1 : v4_len_q;
        if (v4_len_d > V4MaxLen) v4_ok_d = 1'b0;
        pval_d   = (pval_mul > {4'd0, ValSat}) ? ValSat : pval_mul[ValW-1:0];
        if (pval_d > V4MaxValue) v4_ok_d = 1'b0;
        v6_len_d = (v6_len_q != '1) ? v6_len_q + 1'b1 : v6_len_q;
        if (v6_len_d > V6MaxLen) v6_ok_d = 1'b0;
      end else if (cls.is_hex_letter) begin
        v4_ok_d  = 1'b0;
        v6_len_d = (v6_len_q != '1) ? v6_len_q + 1'b1 : v6_len_q;
        if (v6_len_d > V6MaxLen) v6_ok_d = 1'b0;
      end else begin
        v4_ok_d = 1'b0;
        v6_ok_d = 1'b0;
      end
    end
  end

  // End of text closes the open part of both forms.
  assign is_v4 = v4_ok_d && (v4_len_d != '0) && (dot_d == V4Dots);
  assign is_v6 = v6_ok_d && (v6_len_d != '0) && (colon_d == V6Colons);

  always_comb begin
    if (is_v4) begin
      verdict_d = VERDICT_V4;
    end else if (is_v6) begin
      verdict_d = VERDICT_V6;
    end else begin
      verdict_d = VERDICT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q   <= in_i.ch;
      has_q  <= in_i.has_char;
      last_q <= in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_ok_q  <= 1'b1;
      v6_ok_q  <= 1'b1;
      dot_q    <= '0;
      colon_q  <= '0;
      v4_len_q <= '0;
      v6_len_q <= '0;
      pval_q   <= '0;
      lz_q     <= 1'b0;
    end else if (advance) begin
      if (last_q) begin
        // back to the start state for the next text
        v4_ok_q  <= 1'b1;
        v6_ok_q  <= 1'b1;
        dot_q    <= '0;
        colon_q  <= '0;
        v4_len_q <= '0;
        v6_len_q <= '0;
        pval_q   <= '0;
        lz_q     <= 1'b0;
      end else begin
        v4_ok_q  <= v4_ok_d;
        v6_ok_q  <= v6_ok_d;
        dot_q    <= dot_d;
        colon_q  <= colon_d;
        v4_len_q <= v4_len_d;
        v6_len_q <= v6_len_d;
        pval_q   <= pval_d;
        lz_q     <= lz_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      verdict_q <= verdict_d;
    end
  end

endmodule

### hdl/ipav_checker.sv
// Port-level checker for the address validator, bound to the top level.
`timescale 1ns / 1ps
`include "ip_address_validator_assert.svh"

module ipav_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_verdict_i
);

  // Verdict beat holds while the sink stalls.
  `IPAV_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_verdict_i), "verdict beat dropped or changed under stall")

  // Input back-pressure only comes from a stalled verdict.
  `IPAV_NEVER(a_stall_cause, !in_ready_i && !(out_valid_i && !out_ready_i), "input stalled without output stall")

  // A fresh verdict follows an accepted last beat.
  `IPAV_ASSERT(a_verdict_src, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2), "verdict without a last beat")

  // Verdict code 3 never appears.
  `IPAV_NEVER(a_verdict_code, out_valid_i && (out_verdict_i == 2'd3), "undefined verdict code")

endmodule

bind ip_address_validator ipav_checker u_ipav_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_verdict_i (out_o.verdict)
);

### test/address_verdict_checker.sv
// Verdict scoreboard: predicts each address text's verdict and checks the output beats.
`timescale 1ns / 1ps

module address_verdict_checker
  import ipav_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ipav_in_if   in_mon,
  ipav_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  // Scan state of the text in flight, at the block's widths.
  typedef struct packed {
    logic              v4_ok;
    logic              v6_ok;
    logic [DotW-1:0]   dots;
    logic [ColonW-1:0] colons;
    logic [LenW-1:0]   v4_len;
    logic [LenW-1:0]   v6_len;
    logic [ValW-1:0]   value;
    logic              lead_zero;
  } scan_t;

  scan_t    scan;
  verdict_e verdict_q[$];
  int       mismatches = 0;
  int       pending = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  function automatic scan_t fresh_scan();
    scan_t s;
    s       = '0;
    s.v4_ok = 1'b1;
    s.v6_ok = 1'b1;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] verdict check: %s", $time, msg);
    mismatches++;
  endtask

  // appends one predicted verdict at the tail of the queue
  task automatic queue_verdict(input verdict_e v);
    verdict_q.insert(verdict_q.size(), v);
  endtask

  task automatic close_v4_part();
    if (scan.v4_len == '0) scan.v4_ok = 1'b0;
    scan.v4_len    = '0;
    scan.value     = '0;
    scan.lead_zero = 1'b0;
  endtask

  task automatic close_v6_part();
    if (scan.v6_len == '0) scan.v6_ok = 1'b0;
    scan.v6_len = '0;
  endtask

  task automatic bump_v6_len();
    if (scan.v6_len != '1) scan.v6_len = scan.v6_len + 1'b1;
    if (scan.v6_len > V6MaxLen) scan.v6_ok = 1'b0;
  endtask

  // One accepted beat; a last beat queues the verdict and starts a new text.
  task automatic absorb_beat(input logic [7:0] c, input logic has, input logic fin);
    int   nv;
    logic is_digit;
    logic is_hex;
    is_digit = (c >= ChZero) && (c <= ChNine);
    is_hex   = ((c >= ChLowA) && (c <= ChLowF)) || ((c >= ChUpA) && (c <= ChUpF));
    if (has) begin
      if (c == ChDot) begin
        if (scan.dots != '1) scan.dots = scan.dots + 1'b1;
        close_v4_part();
        scan.v6_ok = 1'b0;
      end else if (c == ChColon) begin
        if (scan.colons != '1) scan.colons = scan.colons + 1'b1;
        close_v6_part();
        scan.v4_ok = 1'b0;
      end else if (is_digit) begin
        nv = int'(scan.value) * 10 + int'(c - ChZero);
        if (scan.v4_len == '0) scan.lead_zero = (c == ChZero);
        else if (scan.lead_zero) scan.v4_ok = 1'b0;
        if (scan.v4_len != '1) scan.v4_len = scan.v4_len + 1'b1;
        if (scan.v4_len > V4MaxLen) scan.v4_ok = 1'b0;
        scan.value = (nv > int'(ValSat)) ? ValSat : ValW'(nv);
        if (scan.value > V4MaxValue) scan.v4_ok = 1'b0;
        bump_v6_len();
      end else if (is_hex) begin
        scan.v4_ok = 1'b0;
        bump_v6_len();
      end else begin
        scan.v4_ok = 1'b0;
        scan.v6_ok = 1'b0;
      end
    end
    if (fin) begin
      close_v4_part();
      close_v6_part();
      if (scan.v4_ok && scan.dots == V4Dots) queue_verdict(VERDICT_V4);
      else if (scan.v6_ok && scan.colons == V6Colons) queue_verdict(VERDICT_V6);
      else queue_verdict(VERDICT_NONE);
      scan = fresh_scan();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    verdict_e want;
    if (!rst_ni) begin
      scan = fresh_scan();
      verdict_q.delete();
      pending = 0;
    end else begin
      // output first: a verdict beat always belongs to an earlier text
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict beat %0d with no text ended", out_mon.verdict));
        end else begin
          want = verdict_q.pop_front();
          if (out_mon.verdict !== want)
            report_mismatch($sformatf("verdict %0d, predicted %0d", out_mon.verdict, want));
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_beat(in_mon.ch, in_mon.has_char, in_mon.last);
      pending = verdict_q.size();
    end
  end

endmodule

### test/tb.sv
// Testbench top: drives address texts into the validator and gives the verdict of the run.
`timescale 1ns / 1ps

module tb
  import ipav_pkg::*;
;

  localparam int unsigned ItemTarget    = 1400;
  localparam int unsigned MaxGap        = 14;   // longest idle/stall per beat
  localparam int unsigned WatchdogLimit = 1000; // far above the longest gap and stall together
  localparam int unsigned DrainCycles   = 12;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   items_sent  = 0;

  // sender idle pattern: calm stretches send back to back
  logic in_calm      = 1'b0;
  int   in_calm_left = 0;

  logic [7:0] text_q[$];
  string      hex_set   = "0123456789abcdefABCDEF";
  // bytes at and around the class boundaries: '/' ';' '@' 'G' '`' 'g', space, dash
  string      punct_set = "..::09afAF/;@G`g -";

  ipav_in_if  in_ch ();
  ipav_out_if out_ch ();

  ip_address_validator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  address_verdict_checker verdict_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --- character sender -------------------------------------------------
  // Draws a gap, then holds the beat until accepted. Returns at the accepting
  // edge with valid still high, so back-to-back beats never drop valid.
  task automatic send_beat(input logic [7:0] c, input logic has, input logic fin);
    int gap;
    if (in_calm_left == 0) begin
      in_calm      = ($urandom_range(0, 3) == 0);
      in_calm_left = $urandom_range(10, 60);
    end
    in_calm_left--;
    gap = in_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.ch       <= c;
    in_ch.has_char <= has;
    in_ch.last     <= fin;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    // beats that are neither character nor end mark are ignored by the block
    if (has || fin) items_sent++;
  endtask

  // appends one byte at the tail of the text
  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  // Sends the text in text_q. The end is marked on the final character, or by
  // a separate end-only beat (always so for the empty text). With sprinkle,
  // ignored beats with neither character nor end land between characters now and then.
  task automatic send_text(input bit sep_end, input bit sprinkle);
    for (int i = 0; i < text_q.size(); i++) begin
      if (sprinkle && $urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(text_q[i], 1'b1, !sep_end && (i == text_q.size() - 1));
    end
    if (sep_end || text_q.size() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_dec_digits(input int n);
    for (int i = 0; i < n; i++) add_byte(ChZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_hex_group(input int n);
    for (int i = 0; i < n; i++) add_byte(hex_set[$urandom_range(0, 21)]);
  endtask

  // Random text: mostly well-formed or nearly well-formed addresses so the
  // scan reaches its late states, the rest byte noise.
  task automatic make_random_text();
    int pick;
    int parts;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // dotted quad, values biased to the ends of the range
      for (int p = 0; p < 4; p++) begin
        if (p > 0) add_byte(ChDot);
        case ($urandom_range(0, 3))
          0:       n = 0;
          1:       n = 255;
          default: n = $urandom_range(0, 255);
        endcase
        add_str($sformatf("%0d", n));
      end
    end else if (pick < 45) begin
      // near-quad: empty parts, leading zeros, too many digits, big values,
      // wrong dot counts; rare long ones run the counters into saturation
      parts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : $urandom_range(3, 5);
      for (int p = 0; p < parts; p++) begin
        if (p > 0) add_byte(ChDot);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        add_dec_digits(n);
      end
    end else if (pick < 70) begin
      // full colon form, 1 to 4 hex digits per group, mixed case
      for (int p = 0; p < 8; p++) begin
        if (p > 0) add_byte(ChColon);
        add_hex_group($urandom_range(1, 4));
      end
    end else if (pick < 85) begin
      // near colon form: wrong group counts, empty or long groups
      parts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : $urandom_range(6, 9);
      for (int p = 0; p < parts; p++) begin
        if (p > 0) add_byte(ChColon);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
        add_hex_group(n);
      end
    end else begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++)
        add_byte($urandom_range(0, 1) ? 8'($urandom)
                                      : punct_set[$urandom_range(0, punct_set.len() - 1)]);
    end
    // occasional single-byte corruption of a structured text
    if (pick < 85 && text_q.size() > 0 && $urandom_range(0, 4) == 0)
      text_q[$urandom_range(0, text_q.size() - 1)] =
        $urandom_range(0, 1) ? 8'($urandom) : punct_set[$urandom_range(0, punct_set.len() - 1)];
  endtask

  // --- stimulus and verdict ---------------------------------------------
  initial begin
    rst_ni = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.ch       <= '0;
    in_ch.has_char <= 1'b0;
    in_ch.last     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored beat, then empty text
    send_beat(8'h5A, 1'b0, 1'b0);
    send_text(1'b1, 1'b0);
    add_str("255.0.9.1");           // quad with both value extremes
    send_text(1'b0, 1'b0);
    add_byte(8'hFF);                // high byte, outside every class
    send_text(1'b0, 1'b0);
    add_byte(8'h00);
    send_text(1'b0, 1'b0);
    add_str("f:A");                 // hex letters both cases, too few colons
    send_text(1'b0, 1'b0);
    add_str("01");                  // leading zero
    send_text(1'b0, 1'b0);
    add_str(".");                   // dot alone: empty parts
    send_text(1'b0, 1'b0);
    add_str("7");                   // end marked by an end-only beat
    send_text(1'b1, 1'b0);

    // random texts until the item budget is used
    while (items_sent < ItemTarget) begin
      make_random_text();
      send_text($urandom_range(0, 3) == 0, 1'b1);
    end
    in_ch.valid <= 1'b0;

    // drain: every predicted verdict seen, then a further wait for stray beats
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --- verdict receiver: random stalls, calm stretches with none ----------
  initial begin
    int   stall;
    logic calm;
    int   calm_left;
    out_ch.ready <= 1'b0;
    calm      = 1'b0;
    calm_left = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(3, 15);
      end
      calm_left--;
      stall = calm ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
    end
  end

  // --- watchdog: too long without any beat moving ends the run ------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

### ip_address_validator.f
+incdir+hdl
hdl/ipav_pkg.sv
hdl/ipav_if.sv
hdl/ipav_char_class.sv
hdl/ip_address_validator.sv
hdl/ipav_checker.sv
test/address_verdict_checker.sv
test/tb.sv
